// ===== hw/rtl/htw_pkg.sv =====
// Shared types and constants for the Huffman tree-walk decoder.
// Used by htw_front, htw_queue, htw_back and the core top level; no dependencies.
package htw_pkg;

  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int VB_W           = 4;
  localparam int BYTE_BITS      = 8;
  localparam int CNT_W          = 4;
  localparam int BIT_IX_W       = 3;
  localparam int NODE_COUNT_DEF = 512;
  localparam int QUEUE_DEPTH    = 2;

  // operation field codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // bit counts used by the front end and the walk engine
  localparam logic [CNT_W-1:0] BYTE_DONE = CNT_W'(BYTE_BITS);
  localparam logic [CNT_W-1:0] NO_STOP   = CNT_W'(BYTE_BITS + 1);

  typedef struct packed {
    logic               operation;
    logic [IDX_W-1:0]   node_index;
    logic [IDX_W-1:0]   left_child;
    logic [IDX_W-1:0]   right_child;
    logic               is_leaf;
    logic [SYM_W-1:0]   leaf_symbol;
    logic [SYM_W-1:0]   code_byte;
    logic               last_byte;
    logic [VB_W-1:0]    valid_bits;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic               last_of_byte;
    logic               error;
  } out_item_t;

  // one node store entry: left child in the low bits
  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic               leaf;
    logic [IDX_W-1:0]   right;
    logic [IDX_W-1:0]   left;
  } node_t;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   node_index;
    node_t              node;
    logic [SYM_W-1:0]   code;
    logic               last;
    logic [CNT_W-1:0]   stop_cnt;
  } cmd_t;

endpackage

// ===== hw/rtl/htw_front.sv =====
// Front end: accepts input items, classifies them into queue commands.
// Depends on htw_pkg.
module htw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  htw_pkg::in_item_t in_data,
  output logic              q_push,
  input  logic              q_ready,
  output htw_pkg::cmd_t     q_data
);

  logic          fr_v_r, fr_v_nxt;
  htw_pkg::cmd_t fr_cmd_r;
  htw_pkg::cmd_t cls;

  always_comb begin
    cls.kind        = (in_data.operation == htw_pkg::OP_DECODE) ? htw_pkg::CMD_DECODE
                                                                : htw_pkg::CMD_WRITE;
    cls.node_index  = in_data.node_index;
    cls.node.symbol = in_data.leaf_symbol;
    cls.node.leaf   = in_data.is_leaf;
    cls.node.right  = in_data.right_child;
    cls.node.left   = in_data.left_child;
    cls.code        = in_data.code_byte;
    cls.last        = in_data.last_byte;
    // stop count: bits after which a symbol ends the byte
    if (in_data.last_byte && (in_data.valid_bits != '0) &&
        (in_data.valid_bits <= htw_pkg::VB_W'(htw_pkg::BYTE_BITS))) begin
      cls.stop_cnt = in_data.valid_bits;
    end else begin
      cls.stop_cnt = htw_pkg::NO_STOP;
    end
  end

  assign in_ready = !fr_v_r || q_ready;
  assign q_push   = fr_v_r;
  assign q_data   = fr_cmd_r;

  always_comb begin
    fr_v_nxt = fr_v_r;
    if (in_valid && in_ready) begin
      fr_v_nxt = 1'b1;
    end else if (q_ready) begin
      fr_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_cmd_r <= cls;
    end
  end

endmodule

// ===== hw/rtl/htw_queue.sv =====
// Short command queue between the front end and the walk engine.
// Depends on htw_pkg.
module htw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          push_ready,
  input  htw_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output htw_pkg::cmd_t pop_data
);

  localparam int PW = (htw_pkg::QUEUE_DEPTH > 1) ? $clog2(htw_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(htw_pkg::QUEUE_DEPTH + 1);

  htw_pkg::cmd_t   slot_r [htw_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(htw_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(htw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(htw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/htw_back.sv =====
// Walk engine: node store, tree walk at one bit per cycle on inner nodes, and result register.
// Depends on htw_pkg.
module htw_back #(
  parameter int NODE_COUNT = htw_pkg::NODE_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [htw_pkg::IDX_W-1:0] cfg_data,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  htw_pkg::cmd_t            q_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output htw_pkg::out_item_t       out_data
);

  localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_STEP  = 3'b010,
    S_FLUSH = 3'b100
  } back_state_t;

  back_state_t                state_r, state_nxt;
  logic [htw_pkg::IDX_W-1:0]  pos_r, pos_nxt;
  logic [htw_pkg::IDX_W-1:0]  root_r, root_nxt;
  logic [htw_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       landed_r, landed_nxt;
  htw_pkg::cmd_t              cur_r, cur_nxt;
  logic                       pend_v_r, pend_v_nxt;
  htw_pkg::out_item_t         pend_r, pend_nxt;
  logic                       out_v_r, out_v_nxt;
  htw_pkg::out_item_t         out_r, out_nxt;

  htw_pkg::node_t             node_mem [NODE_COUNT];
  htw_pkg::node_t             mem_q_r;
  logic                       oob_r;
  htw_pkg::node_t             ent;

  logic                       rd_en;
  logic [htw_pkg::IDX_W-1:0]  rd_idx;
  logic                       wr_en;
  logic                       can_push, push, push_last;
  logic [htw_pkg::IDX_W-1:0]  child;

  // node store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[q_data.node_index[IW-1:0]] <= q_data.node;
    end
    if (rd_en) begin
      mem_q_r <= node_mem[rd_idx[IW-1:0]];
      oob_r   <= !(32'(rd_idx) < NODE_COUNT);
    end
  end

  // an index past the store reads as an all-zero inner node
  assign ent      = oob_r ? '0 : mem_q_r;
  assign can_push = !out_v_r || out_ready;
  assign child    = cur_r.code[cnt_r[htw_pkg::BIT_IX_W-1:0]] ? ent.right : ent.left;

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    root_nxt   = root_r;
    cnt_nxt    = cnt_r;
    landed_nxt = landed_r;
    cur_nxt    = cur_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    rd_en      = 1'b0;
    rd_idx     = pos_r;
    wr_en      = 1'b0;
    q_pop      = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.kind == htw_pkg::CMD_WRITE) begin
            wr_en = (32'(q_data.node_index) < NODE_COUNT);
          end else begin
            cur_nxt    = q_data;
            rd_en      = 1'b1;
            rd_idx     = pos_r;
            cnt_nxt    = '0;
            landed_nxt = 1'b0;
            state_nxt  = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (ent.leaf) begin
          if (!pend_v_r || can_push) begin
            push                  = pend_v_r;
            pend_v_nxt            = 1'b1;
            pend_nxt.symbol       = landed_r ? ent.symbol : '0;
            pend_nxt.error        = !landed_r;
            pend_nxt.last_of_byte = 1'b0;
            pos_nxt               = root_r;
            if (!landed_r || (cnt_r >= cur_r.stop_cnt) || (cnt_r == htw_pkg::BYTE_DONE)) begin
              state_nxt = S_FLUSH;
            end else begin
              rd_en      = 1'b1;
              rd_idx     = root_r;
              landed_nxt = 1'b0;
            end
          end
        end else if (cnt_r == htw_pkg::BYTE_DONE) begin
          state_nxt = S_FLUSH;
        end else begin
          pos_nxt    = child;
          rd_en      = 1'b1;
          rd_idx     = child;
          cnt_nxt    = cnt_r + 1'b1;
          landed_nxt = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r || can_push) begin
          push       = pend_v_r;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
          if (cur_r.last) begin
            pos_nxt = root_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      root_nxt = cfg_data;
      pos_nxt  = cfg_data;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (push) begin
      out_v_nxt            = 1'b1;
      out_nxt              = pend_r;
      out_nxt.last_of_byte = push_last;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      root_r   <= '0;
      cnt_r    <= '0;
      landed_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      root_r   <= root_nxt;
      cnt_r    <= cnt_nxt;
      landed_r <= landed_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/huffman_tree_walk_decoder_core.sv =====
// A node write passes the front register and a queue slot before it lands in the node store; a
// code byte passes the same two and is popped while its current node is fetched. The walk then
// takes a step for that fetch, a step for each consumed bit, a root refetch for each decoded
// symbol or a last check of a walk left mid-tree, and a step to close the byte; an error or early
// stop ends it sooner. A new command is popped only back in idle; the store has a single read port.
// Synchronous reset (rst_n) zeroes root and walk position, empties the queue, keeps the store.
// Core top level: front end, command queue and walk engine; depends on htw_pkg.
module huffman_tree_walk_decoder_core #(
  parameter int NODE_COUNT = htw_pkg::NODE_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input item channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  htw_pkg::in_item_t         in_data,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output htw_pkg::out_item_t        out_data,
  // root node register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [htw_pkg::IDX_W-1:0] cfg_data
);

  // front to queue
  logic          fq_push;
  logic          fq_ready;
  htw_pkg::cmd_t fq_data;
  // queue to walk engine
  logic          qb_valid;
  logic          qb_pop;
  htw_pkg::cmd_t qb_data;
  logic          cfg_we;

  // always ready; the user writes root only while the core is idle, not enforced
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // classify items and hold one in a register ahead of the queue
  htw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (fq_push),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  // decouple intake from the walk so either side can stall on its own
  htw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fq_push),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop        (qb_pop),
    .pop_data   (qb_data)
  );

  // walk the stored tree one bit per cycle on inner nodes, hold the newest result until the next
  // one or the end of the byte shows whether it is the last of its byte
  htw_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (qb_valid),
    .q_pop     (qb_pop),
    .q_data    (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // hold a command that the full queue refuses, unchanged, until it is taken
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fq_push && !fq_ready) |=> (fq_push && $stable(fq_data)))
    else $error("front dropped or changed a waiting command");

  // the walk engine pops only a present command
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    qb_pop |-> qb_valid)
    else $error("walk engine popped an empty queue");

  // an error result always carries a zero symbol
  a_err_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |-> (out_data.symbol == '0))
    else $error("error result with nonzero symbol");
`endif

endmodule
